[sv/asc_pkg.sv]
// Shared constants and control structures for the stillness capture block.
package asc_pkg;

    localparam int WINDOW_LEN_DEF = 32;
    localparam int SET_SIZE_DEF   = 6;

    localparam int AXES     = 3;
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 48;
    localparam int SLOT_W   = 6;

    // Pipeline stages: A..D live in the axis lanes, E and F in the merge unit.
    localparam int NSTG = 6;
    localparam int STG_A = 0;
    localparam int STG_B = 1;
    localparam int STG_C = 2;
    localparam int STG_D = 3;
    localparam int STG_E = 4;
    localparam int STG_F = 5;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic load_d;
    } t_lane_ctrl;

    typedef struct packed {
        logic load_e;
        logic load_f;
    } t_merge_ctrl;

endpackage

[sv/asc_lane.sv]
// One axis lane: sample window, running sums, scaled deviation and floor mean.
module asc_lane #(
    parameter int WINDOW_LEN = asc_pkg::WINDOW_LEN_DEF,
    localparam int LOG_W = $clog2(WINDOW_LEN),
    localparam int DEV_W = 31 + 2 * LOG_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  asc_pkg::t_lane_ctrl                  i_ctrl,
    input  logic signed [asc_pkg::SAMPLE_W-1:0]  i_sample,
    output logic [DEV_W-1:0]                     o_dev,
    output logic [asc_pkg::SAMPLE_W-1:0]         o_mean
);

    localparam int SUM_W  = asc_pkg::SAMPLE_W + LOG_W;
    localparam int SQ_W   = 31 + LOG_W;
    localparam int RCP_SH = SUM_W + LOG_W;
    localparam int RCP_W  = SUM_W + 2;
    localparam int PRD_W  = SUM_W + RCP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RCP_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam int MEAN_OFS = WINDOW_LEN * 32768;
    localparam logic [LOG_W:0] WLEN = (LOG_W + 1)'(WINDOW_LEN);

    logic signed [asc_pkg::SAMPLE_W-1:0] r_win [WINDOW_LEN];

    // Stage A: running first-order sum and fresh squares.
    logic signed [SUM_W-1:0] r_s1;
    logic [30:0]             r_sq_new;
    logic [30:0]             r_sq_old;
    logic signed [31:0]      sq_new_full;
    logic signed [31:0]      sq_old_full;

    // Stage B: running sum of squares.
    logic [SQ_W-1:0]         r_s2;
    logic signed [SUM_W-1:0] r_s1_b;

    // Stage C: products.
    logic [DEV_W-1:0]            r_s1sq;
    logic [DEV_W-1:0]            r_ws2;
    logic [asc_pkg::SAMPLE_W-1:0] r_q;
    logic signed [2*SUM_W-1:0]   s1sq_full;
    logic [SQ_W+LOG_W:0]         ws2_full;
    logic [SUM_W-1:0]            u_ofs;
    logic [PRD_W-1:0]            qprod_full;

    // Stage D: lane results.
    logic [DEV_W-1:0]             r_dev;
    logic [asc_pkg::SAMPLE_W-1:0] r_mean;

    assign sq_new_full = i_sample * i_sample;
    assign sq_old_full = r_win[0] * r_win[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_s1 <= '0;
        end else if (i_ctrl.load_a) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW_LEN-1] <= i_sample;
            r_s1 <= r_s1 + SUM_W'(i_sample) - SUM_W'(r_win[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_a) begin
            r_sq_new <= sq_new_full[30:0];
            r_sq_old <= sq_old_full[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (i_ctrl.load_b) begin
            r_s2 <= r_s2 + SQ_W'(r_sq_new) - SQ_W'(r_sq_old);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_b) begin
            r_s1_b <= r_s1;
        end
    end

    // Offsetting the sum by WINDOW_LEN * 32768 makes it non-negative, so the
    // floor division becomes an unsigned reciprocal multiply that is exact
    // for every sum the window can produce.
    assign s1sq_full  = r_s1_b * r_s1_b;
    assign ws2_full   = (SQ_W + LOG_W + 1)'(r_s2) * (SQ_W + LOG_W + 1)'(WLEN);
    assign u_ofs      = unsigned'(r_s1_b) + SUM_W'(MEAN_OFS);
    assign qprod_full = PRD_W'(u_ofs) * PRD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_c) begin
            r_s1sq <= s1sq_full[DEV_W-1:0];
            r_ws2  <= ws2_full[DEV_W-1:0];
            r_q    <= qprod_full[RCP_SH+asc_pkg::SAMPLE_W-1:RCP_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_d) begin
            r_dev  <= r_ws2 - r_s1sq;
            r_mean <= {~r_q[asc_pkg::SAMPLE_W-1], r_q[asc_pkg::SAMPLE_W-2:0]};
        end
    end

    assign o_dev  = r_dev;
    assign o_mean = r_mean;

endmodule

[sv/asc_merge.sv]
// Merge unit: totals the lane deviations, checks stillness and tracks the slot.
module asc_merge #(
    parameter int WINDOW_LEN = asc_pkg::WINDOW_LEN_DEF,
    parameter int SET_SIZE   = asc_pkg::SET_SIZE_DEF,
    localparam int DEV_W = 31 + 2 * $clog2(WINDOW_LEN)
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  asc_pkg::t_merge_ctrl                                i_ctrl,
    input  logic [asc_pkg::THR_W-1:0]                           i_thr,
    input  logic [asc_pkg::AXES-1:0][DEV_W-1:0]                 i_dev,
    input  logic [asc_pkg::AXES-1:0][asc_pkg::SAMPLE_W-1:0]     i_mean,
    output logic                                                o_still,
    output logic [asc_pkg::AXES-1:0][asc_pkg::SAMPLE_W-1:0]     o_mean,
    output logic [asc_pkg::SLOT_W-1:0]                          o_slot,
    output logic                                                o_done
);

    localparam int TOT_W = DEV_W + 2;
    localparam int CMP_W = (TOT_W > asc_pkg::THR_W) ? TOT_W : asc_pkg::THR_W;
    localparam logic [asc_pkg::SLOT_W-1:0] LAST_SLOT = asc_pkg::SLOT_W'(SET_SIZE - 1);

    logic [TOT_W-1:0]                                   r_tot;
    logic [asc_pkg::AXES-1:0][asc_pkg::SAMPLE_W-1:0]    r_mean_e;
    logic [asc_pkg::SLOT_W-1:0]                         r_slot_cnt;
    logic [asc_pkg::SLOT_W-1:0]                         n_slot_cnt;
    logic                                               still;
    logic                                               wrap;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_e) begin
            r_tot    <= TOT_W'(i_dev[0]) + TOT_W'(i_dev[1]) + TOT_W'(i_dev[2]);
            r_mean_e <= i_mean;
        end
    end

    assign still = CMP_W'(r_tot) < CMP_W'(i_thr);
    assign wrap  = (r_slot_cnt == LAST_SLOT);

    always_comb begin
        n_slot_cnt = r_slot_cnt;
        if (still) begin
            n_slot_cnt = wrap ? '0 : r_slot_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt <= '0;
        end else if (i_ctrl.load_f) begin
            r_slot_cnt <= n_slot_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_f) begin
            o_still <= still;
            o_mean  <= r_mean_e;
            o_slot  <= still ? r_slot_cnt : '0;
            o_done  <= still && wrap;
        end
    end

endmodule

[sv/accel_stillness_capture.sv]
// Top level of the accelerometer stillness capture block.

// Each input beat carries one three-axis accelerometer sample, and each
// sample produces exactly one output beat, in order. Three identical axis
// lanes keep a shift window of the last WINDOW_LEN samples (all zero after
// reset, and those zeros count as real samples), a running sum and a running
// sum of squares, and derive the floor mean and WINDOW_LEN times the squared
// deviation of their axis. A merge unit adds the three deviations; when the
// total is strictly below the still threshold the window is still, the beat
// carries the capture slot in tuser-flagged form and the slot count advances,
// wrapping to zero after SET_SIZE captures with tlast marking the beat that
// completed the set. When the window is not still, tuser, tlast and the slot
// are zero while the means are still reported. The block accepts one beat per
// clock cycle unless all stages are full; the first-order sum closes in stage A,
// the sum of squares in stage B, and every later step is a registered
// pipeline stage, so a beat passes stages A to F in order, and up to six
// beats are in flight. The ready chain runs combinationally through all six
// stages, so any empty stage keeps the input ready while a result waits; the
// input stalls only once all six stages hold a beat.
// The threshold resets to zero, which suppresses every capture, and may only
// be written while the block is idle. Both the sample input and the threshold
// port are ready only while reset is released.
module accel_stillness_capture #(
    parameter int WINDOW_LEN = asc_pkg::WINDOW_LEN_DEF,
    parameter int SET_SIZE   = asc_pkg::SET_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic [47:0] i_s_axis_tdata,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // mean_x [15:0], mean_y [31:16], mean_z [47:32], capture_slot [53:48], zero fill
    output logic [55:0] o_m_axis_tdata,
    // still_capture [0]
    output logic [0:0]  o_m_axis_tuser,
    // set_complete
    output logic        o_m_axis_tlast,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_cfg_data
);

    localparam int DEV_W = 31 + 2 * $clog2(WINDOW_LEN);

    logic [asc_pkg::THR_W-1:0] r_thr;

    logic [asc_pkg::NSTG-1:0] r_vld;
    logic [asc_pkg::NSTG-1:0] n_vld;
    logic [asc_pkg::NSTG-1:0] free;
    logic [asc_pkg::NSTG-1:0] load;

    asc_pkg::t_lane_ctrl  lane_ctrl;
    asc_pkg::t_merge_ctrl merge_ctrl;

    logic [asc_pkg::AXES-1:0][DEV_W-1:0]              lane_dev;
    logic [asc_pkg::AXES-1:0][asc_pkg::SAMPLE_W-1:0]  lane_mean;
    logic [asc_pkg::AXES-1:0][asc_pkg::SAMPLE_W-1:0]  out_mean;
    logic [asc_pkg::SLOT_W-1:0]                       out_slot;
    logic                                             out_still;
    logic                                             out_done;

    // Threshold register. Writes are refused while reset is asserted.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // Pipeline occupancy. A stage is free when it is empty or its item moves
    // on this cycle; an item loads into a stage when the one before holds an
    // item and the stage is free.
    always_comb begin
        free[asc_pkg::STG_F] = !r_vld[asc_pkg::STG_F] || i_m_axis_tready;
        for (int k = asc_pkg::NSTG - 2; k >= 0; k--) begin
            free[k] = !r_vld[k] || free[k+1];
        end
        load[asc_pkg::STG_A] = i_s_axis_tvalid && free[asc_pkg::STG_A];
        for (int k = 1; k < asc_pkg::NSTG; k++) begin
            load[k] = r_vld[k-1] && free[k];
        end
        for (int k = 0; k < asc_pkg::NSTG; k++) begin
            n_vld[k] = load[k] || (r_vld[k] && !free[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // No sample beat is taken while reset is asserted.
    assign o_s_axis_tready = free[asc_pkg::STG_A] && i_rst_n;
    assign o_m_axis_tvalid = r_vld[asc_pkg::STG_F];

    assign lane_ctrl.load_a  = load[asc_pkg::STG_A];
    assign lane_ctrl.load_b  = load[asc_pkg::STG_B];
    assign lane_ctrl.load_c  = load[asc_pkg::STG_C];
    assign lane_ctrl.load_d  = load[asc_pkg::STG_D];
    assign merge_ctrl.load_e = load[asc_pkg::STG_E];
    assign merge_ctrl.load_f = load[asc_pkg::STG_F];

    // One lane per axis, all stepping together.
    for (genvar a = 0; a < asc_pkg::AXES; a++) begin : g_lane
        asc_lane #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (lane_ctrl),
            .i_sample (signed'(i_s_axis_tdata[a*asc_pkg::SAMPLE_W +: asc_pkg::SAMPLE_W])),
            .o_dev    (lane_dev[a]),
            .o_mean   (lane_mean[a])
        );
    end

    asc_merge #(
        .WINDOW_LEN (WINDOW_LEN),
        .SET_SIZE   (SET_SIZE)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (merge_ctrl),
        .i_thr   (r_thr),
        .i_dev   (lane_dev),
        .i_mean  (lane_mean),
        .o_still (out_still),
        .o_mean  (out_mean),
        .o_slot  (out_slot),
        .o_done  (out_done)
    );

    assign o_m_axis_tdata = {2'b00, out_slot, out_mean[2], out_mean[1], out_mean[0]};
    assign o_m_axis_tuser = out_still;
    assign o_m_axis_tlast = out_done;

    // A completed set is always a capture.
    a_done_is_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser[0])
        else $error("set completion without a capture");

    // Without a capture the slot field reads zero.
    a_idle_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[53:48] == '0)
        else $error("slot reported without a capture");

    // Captured slots stay inside the set.
    a_slot_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> 32'(o_m_axis_tdata[53:48]) < SET_SIZE)
        else $error("capture slot beyond set size");

    // An accepted beat occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[asc_pkg::STG_A])
        else $error("accepted beat lost at the first stage");

endmodule

[sim/tb_accel_stillness_capture.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the accelerometer stillness capture block.
module tb_accel_stillness_capture;

    localparam int AXES = asc_pkg::AXES;
    localparam int SAMPLE_W = asc_pkg::SAMPLE_W;
    localparam int THR_W = asc_pkg::THR_W;
    localparam int SLOT_W = asc_pkg::SLOT_W;
    localparam int WIN = asc_pkg::WINDOW_LEN_DEF;
    localparam int SET = asc_pkg::SET_SIZE_DEF;
    localparam int BEAT_W = AXES * SAMPLE_W;
    localparam int PHASE_ITEMS = 135;
    localparam int LONG_HOLD = 300;
    localparam int REPORT_LIMIT = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    // One predicted output beat: the three window means, the capture slot,
    // the still flag (tuser) and the set completion flag (tlast).
    typedef struct packed {
        logic [AXES-1:0][SAMPLE_W-1:0] mean;
        logic [SLOT_W-1:0]             slot;
        logic                          still;
        logic                          done;
    } t_capture;

    // Tracks the sample window and the slot count exactly as the block should,
    // queues one predicted beat per accepted sample and checks the outputs
    // against that queue in order.
    class stillness_tracker;
        logic signed [SAMPLE_W-1:0] history [WIN][AXES];
        int                         oldest;
        longint                     axis_sum [AXES];
        longint                     axis_sq_sum [AXES];
        int                         slot_fill;
        logic [THR_W-1:0]           threshold;
        t_capture                   pending_captures [$];
        int                         mismatch_count;

        function new();
            foreach (history[i, a]) history[i][a] = '0;
            foreach (axis_sum[a]) begin
                axis_sum[a] = 0;
                axis_sq_sum[a] = 0;
            end
            oldest = 0;
            slot_fill = 0;
            threshold = '0;
            mismatch_count = 0;
        endfunction

        function void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("mismatch at %0t: %s expected 0x%0h, got 0x%0h", $realtime, what,
                         want, got);
            end
        endfunction

        function void accept_sample(logic [BEAT_W-1:0] beat);
            t_capture pred;
            longint   s;
            longint   old;
            longint   q;
            longint   spread;
            spread = 0;
            for (int a = 0; a < AXES; a++) begin
                s = longint'($signed(beat[a*SAMPLE_W +: SAMPLE_W]));
                old = longint'(history[oldest][a]);
                axis_sum[a] += s - old;
                axis_sq_sum[a] += s * s - old * old;
                history[oldest][a] = beat[a*SAMPLE_W +: SAMPLE_W];
                // Floor division: truncation is wrong for negative sums.
                q = axis_sum[a] / WIN;
                if ((axis_sum[a] % WIN) != 0 && axis_sum[a] < 0) q--;
                pred.mean[a] = q[SAMPLE_W-1:0];
                spread += WIN * axis_sq_sum[a] - axis_sum[a] * axis_sum[a];
            end
            oldest = (oldest + 1) % WIN;
            pred.still = spread < longint'({16'b0, threshold});
            pred.slot = '0;
            pred.done = 1'b0;
            if (pred.still) begin
                pred.slot = SLOT_W'(slot_fill);
                slot_fill++;
                if (slot_fill >= SET) begin
                    slot_fill = 0;
                    pred.done = 1'b1;
                end
            end
            pending_captures.push_back(pred);
        endfunction

        function void check_capture(logic [55:0] data, logic [0:0] user, logic last);
            t_capture want;
            if (pending_captures.size() == 0) begin
                note_mismatch("output beat with nothing pending", '0, 64'(data));
                return;
            end
            want = pending_captures.pop_front();
            for (int a = 0; a < AXES; a++) begin
                if (data[a*SAMPLE_W +: SAMPLE_W] !== want.mean[a]) begin
                    note_mismatch($sformatf("mean of axis %0d", a), 64'(want.mean[a]),
                                  64'(data[a*SAMPLE_W +: SAMPLE_W]));
                end
            end
            if (data[BEAT_W +: SLOT_W] !== want.slot)
                note_mismatch("capture_slot", 64'(want.slot), 64'(data[BEAT_W +: SLOT_W]));
            if (data[55:BEAT_W+SLOT_W] !== '0)
                note_mismatch("tdata fill bits", '0, 64'(data[55:BEAT_W+SLOT_W]));
            if (user[0] !== want.still)
                note_mismatch("still_capture", 64'(want.still), 64'(user[0]));
            if (last !== want.done)
                note_mismatch("set_complete", 64'(want.done), 64'(last));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [47:0]       i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [55:0]       o_m_axis_tdata;
    logic [0:0]        o_m_axis_tuser;
    logic              o_m_axis_tlast;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [THR_W-1:0]  i_cfg_data;

    stillness_tracker tracker = new();

    // Idle percentages per side, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // The stimulus asks for a long output stall by bumping the request count;
    // the receiver serves each request in its own process.
    int hold_requests = 0;
    int cycles = 0;

    accel_stillness_capture u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturates a signed value into the 16 bit sample range.
    function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [BEAT_W-1:0] pack_sample(int x, int y, int z);
        return {clamp_sample(z), clamp_sample(y), clamp_sample(x)};
    endfunction

    // Offers one sample beat, with random idle cycles ahead of it, and hands it
    // to the tracker at the edge where the block accepts it. tvalid is only
    // assigned once per edge, so a back-to-back beat never glitches low.
    task automatic send_sample(input logic [BEAT_W-1:0] beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= beat;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.accept_sample(beat);
    endtask

    // Every sample yields exactly one output beat, so the block is idle once
    // the tracker has nothing pending and the input side has gone quiet.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending_captures.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.threshold = value;
    endtask

    // Random phase. Most of the traffic is runs of samples around a common
    // base with bounded jitter, which is what lets the window settle and the
    // deviation drop under the threshold. One pick in ten is a single beat of
    // raw noise over the full 48 bits instead, which also breaks up settling runs.
    task automatic run_phase(input int count);
        int                sent;
        int                len;
        int                amp;
        int                base [AXES];
        logic [BEAT_W-1:0] beat;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                beat = {16'($urandom()), 32'($urandom())};
                send_sample(beat);
                sent++;
            end else begin
                len = $urandom_range(8, 70);
                amp = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 40);
                foreach (base[a]) begin
                    if ($urandom_range(3) == 0)
                        base[a] = $urandom_range(1) ? 32767 : -32768;
                    else
                        base[a] = $signed(16'($urandom()));
                end
                for (int i = 0; i < len && sent < count; i++) begin
                    for (int a = 0; a < AXES; a++) begin
                        beat[a*SAMPLE_W +: SAMPLE_W] =
                            clamp_sample(base[a] + int'($urandom_range(0, 2 * amp)) - amp);
                    end
                    send_sample(beat);
                    sent++;
                end
            end
        end
    endtask

    // Output side: checks every accepted result beat, then decides tready for
    // the next cycle. A pending long-stall request takes precedence over the
    // random idling and holds tready low until its hold countdown runs out.
    initial begin
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                tracker.check_capture(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog. CYCLE_LIMIT leaves a wide margin over a correct run with the
    // worst idling mix plus the long output stall.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [THR_W-1:0] thr;
        longint           amp;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset threshold of zero: nothing may be
        // captured, even for an all-zero sample on an all-zero window. The
        // window is not full yet, so the reset zeros dilute every mean.
        send_sample(pack_sample(0, 0, 0));
        send_sample(pack_sample(32767, 32767, 32767));
        send_sample(pack_sample(-32768, -32768, -32768));
        send_sample(pack_sample(-1, -1, -1));
        send_sample(pack_sample(1, -1, 0));
        send_sample(pack_sample(-32768, 32767, -1));
        wait_idle();

        // Largest threshold: every window counts as still, so the slot count
        // walks through the set and wraps twice. Negative running sums check
        // that the mean rounds toward minus infinity.
        set_threshold(THR_MAX);
        send_sample(pack_sample(32767, -32768, 32767));
        send_sample(pack_sample(-32768, 32767, -32768));
        for (int i = 0; i < 10; i++)
            send_sample(pack_sample(-3 - i, -32768, 5 * i - 17));
        send_sample(pack_sample(-32768, -32768, -32768));
        wait_idle();

        // Random phases: two per idling mix. The thresholds include one (only
        // a perfectly constant window passes), the maximum, zero again, and
        // values scaled to the jitter of the runs so both outcomes occur.
        for (int phase = 0; phase < 6; phase++) begin
            unique case (phase / 2)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            amp = longint'($urandom_range(1, 40));
            unique case (phase)
                0: thr = 48'd1;
                2: thr = THR_MAX;
                4: thr = '0;
                default: thr = THR_W'(longint'(WIN * WIN) * amp * amp
                                      * longint'($urandom_range(1, 6)));
            endcase
            set_threshold(thr);
            // With free-running traffic on both sides, stall the output for a
            // long stretch so the pipeline fills and backpressures the input.
            if (phase == 4) hold_requests++;
            run_phase(PHASE_ITEMS);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending_captures.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
